>>> hw/rtl/rv32i_subset_executor_defines.svh
// Assertion macros used by the executor top level.
`ifndef RV32I_SUBSET_EXECUTOR_DEFINES_SVH
`define RV32I_SUBSET_EXECUTOR_DEFINES_SVH

// Same-cycle implication.
`define RSX_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RSX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rsx_pkg.sv
package rsx_pkg;

   localparam int MEM_BYTES_DEF      = 4096;
   localparam int TEXT_WORDS_MAX_DEF = 256;
   localparam int STEP_LIMIT_DEF     = 1000;

   typedef enum logic [2:0] {
      CMD_LOAD_TEXT = 3'd0,
      CMD_LOAD_DATA = 3'd1,
      CMD_STEP      = 3'd2,
      CMD_READ_REG  = 3'd3,
      CMD_READ_MEM  = 3'd4
   } cmd_type;

   typedef enum logic [4:0] {
      ST_OK         = 5'd0,
      ST_HALT       = 5'd1,
      ST_PC_OUT     = 5'd2,
      ST_R_TYPE     = 5'd3,
      ST_I_TYPE     = 5'd4,
      ST_LOAD_KIND  = 5'd5,
      ST_LW_ALIGN   = 5'd6,
      ST_LW_RANGE   = 5'd7,
      ST_STORE_KIND = 5'd8,
      ST_SW_ALIGN   = 5'd9,
      ST_SW_RANGE   = 5'd10,
      ST_SW_TEXT    = 5'd11,
      ST_BR_KIND    = 5'd12,
      ST_BR_TARGET  = 5'd13,
      ST_OPCODE     = 5'd14,
      ST_LIMIT      = 5'd15,
      ST_TEXT_FULL  = 5'd16,
      ST_TEXT_LATE  = 5'd17,
      ST_DATA_ADDR  = 5'd18,
      ST_STARTED    = 5'd19,
      ST_STOPPED    = 5'd20
   } status_type;

   localparam logic [6:0] OP_R      = 7'h33;
   localparam logic [6:0] OP_I      = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_SUB  = 7'h20;

   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_SW  = 3'd2;
   localparam logic [2:0] F3_BEQ = 3'd0;
   localparam logic [2:0] F3_BNE = 3'd1;
   localparam logic [2:0] F3_BLT = 3'd4;
   localparam logic [2:0] F3_BGE = 3'd5;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_READ,
      FSM_FETCH,
      FSM_EXEC,
      FSM_LOAD
   } fsm_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] addr;
      logic [31:0] word;
   } req_type;

   typedef struct packed {
      logic [4:0]  status;
      logic [9:0]  step_index;
      logic [10:0] pc;
      logic [31:0] insn;
      logic [4:0]  dest_reg;
      logic [31:0] write_value;
      logic [31:0] mem_addr;
      logic        branch_taken;
      logic [10:0] next_pc;
      logic [31:0] read_data;
   } rsp_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  dest_reg;
      logic [31:0] write_value;
      logic [31:0] wb_value;
      logic [31:0] mem_addr;
      logic        branch_taken;
      logic [31:0] next_pc;
      logic        reg_we;
      logic        mem_we;
      logic        is_load;
   } exec_res_type;

endpackage

>>> hw/rtl/rsx_regfile.sv
module rsx_regfile (
   input  logic        clock,
   input  logic        we,
   input  logic [4:0]  waddr,
   input  logic [31:0] wdata,
   input  logic        re_a,
   input  logic [4:0]  raddr_a,
   input  logic        re_b,
   input  logic [4:0]  raddr_b,
   output logic [31:0] rdata_a,
   output logic [31:0] rdata_b
);

   logic [31:0] reg_array [32];
   logic [31:0] rdata_a_ff;
   logic [31:0] rdata_b_ff;

   // read data holds until the next read on that port
   always_ff @(posedge clock) begin
      if (we) begin
         reg_array[waddr] <= wdata;
      end
      if (re_a) begin
         rdata_a_ff <= reg_array[raddr_a];
      end
      if (re_b) begin
         rdata_b_ff <= reg_array[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> hw/rtl/rsx_word_mem.sv
module rsx_word_mem #(
   parameter int MEM_WORDS = rsx_pkg::MEM_BYTES_DEF / 4
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(MEM_WORDS)-1:0] waddr,
   input  logic [31:0]                  wdata,
   input  logic                         re,
   input  logic [$clog2(MEM_WORDS)-1:0] raddr,
   output logic [31:0]                  rdata
);

   logic [31:0] word_array [MEM_WORDS];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         word_array[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= word_array[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/rsx_exec.sv
module rsx_exec #(
   parameter int MEM_BYTES = rsx_pkg::MEM_BYTES_DEF
) (
   input  logic [31:0]          insn,
   input  logic [31:0]          rs1_val,
   input  logic [31:0]          rs2_val,
   input  logic [31:0]          pc,
   input  logic [31:0]          text_end,
   output rsx_pkg::exec_res_type res
);

   localparam logic [31:0] MEM_LAST = 32'(MEM_BYTES - 4);

   logic [6:0]  opcode;
   logic [4:0]  rd;
   logic [2:0]  funct3;
   logic [6:0]  funct7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] ea_i;
   logic [31:0] ea_s;
   logic [31:0] seq_pc;
   logic [31:0] br_pc;
   logic [31:0] target;
   logic [31:0] alu_val;
   logic        less;
   logic        take;
   logic        alu_ok;

   assign opcode = insn[6:0];
   assign rd     = insn[11:7];
   assign funct3 = insn[14:12];
   assign funct7 = insn[31:25];

   assign imm_i = {{20{insn[31]}}, insn[31:20]};
   assign imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
   assign imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};

   assign ea_i   = rs1_val + imm_i;
   assign ea_s   = rs1_val + imm_s;
   assign seq_pc = pc + 32'd4;
   assign br_pc  = pc + imm_b;
   assign less   = $signed(rs1_val) < $signed(rs2_val);
   assign target = take ? br_pc : seq_pc;

   // ALU value for register and immediate forms
   always_comb begin
      alu_val = '0;
      alu_ok  = 1'b1;
      if (opcode == rsx_pkg::OP_R) begin
         if (funct3 == rsx_pkg::F3_ADD && funct7 == rsx_pkg::F7_BASE) begin
            alu_val = rs1_val + rs2_val;
         end else if (funct3 == rsx_pkg::F3_ADD && funct7 == rsx_pkg::F7_SUB) begin
            alu_val = rs1_val - rs2_val;
         end else if (funct3 == rsx_pkg::F3_AND && funct7 == rsx_pkg::F7_BASE) begin
            alu_val = rs1_val & rs2_val;
         end else if (funct3 == rsx_pkg::F3_OR && funct7 == rsx_pkg::F7_BASE) begin
            alu_val = rs1_val | rs2_val;
         end else begin
            alu_ok = 1'b0;
         end
      end else begin
         if (funct3 == rsx_pkg::F3_ADD) begin
            alu_val = rs1_val + imm_i;
         end else if (funct3 == rsx_pkg::F3_AND) begin
            alu_val = rs1_val & imm_i;
         end else if (funct3 == rsx_pkg::F3_OR) begin
            alu_val = rs1_val | imm_i;
         end else begin
            alu_ok = 1'b0;
         end
      end
   end

   always_comb begin
      take = 1'b0;
      case (funct3)
         rsx_pkg::F3_BEQ: take = (rs1_val == rs2_val);
         rsx_pkg::F3_BNE: take = (rs1_val != rs2_val);
         rsx_pkg::F3_BLT: take = less;
         rsx_pkg::F3_BGE: take = !less;
         default:         take = 1'b0;
      endcase
   end

   always_comb begin
      res         = '0;
      res.status  = rsx_pkg::ST_OK;
      res.next_pc = seq_pc;
      unique case (opcode)
         rsx_pkg::OP_R, rsx_pkg::OP_I: begin
            if (!alu_ok) begin
               res.status = (opcode == rsx_pkg::OP_R) ? rsx_pkg::ST_R_TYPE
                                                      : rsx_pkg::ST_I_TYPE;
            end
            res.reg_we      = 1'b1;
            res.dest_reg    = rd;
            res.wb_value    = alu_val;
            res.write_value = (rd != 5'd0) ? alu_val : 32'd0;
         end
         rsx_pkg::OP_LOAD: begin
            if (funct3 != rsx_pkg::F3_LW) begin
               res.status = rsx_pkg::ST_LOAD_KIND;
            end else if (ea_i[1:0] != 2'd0) begin
               res.status = rsx_pkg::ST_LW_ALIGN;
            end else if (ea_i > MEM_LAST) begin
               res.status = rsx_pkg::ST_LW_RANGE;
            end
            res.is_load  = 1'b1;
            res.reg_we   = 1'b1;
            res.dest_reg = rd;
            res.mem_addr = ea_i;
         end
         rsx_pkg::OP_STORE: begin
            if (funct3 != rsx_pkg::F3_SW) begin
               res.status = rsx_pkg::ST_STORE_KIND;
            end else if (ea_s[1:0] != 2'd0) begin
               res.status = rsx_pkg::ST_SW_ALIGN;
            end else if (ea_s > MEM_LAST) begin
               res.status = rsx_pkg::ST_SW_RANGE;
            end else if (ea_s < text_end) begin
               res.status = rsx_pkg::ST_SW_TEXT;
            end
            res.mem_we      = 1'b1;
            res.write_value = rs2_val;
            res.mem_addr    = ea_s;
         end
         rsx_pkg::OP_BRANCH: begin
            if (funct3 != rsx_pkg::F3_BEQ && funct3 != rsx_pkg::F3_BNE &&
                funct3 != rsx_pkg::F3_BLT && funct3 != rsx_pkg::F3_BGE) begin
               res.status = rsx_pkg::ST_BR_KIND;
            end else if (target[1:0] != 2'd0 || target > text_end) begin
               res.status = rsx_pkg::ST_BR_TARGET;
            end
            res.branch_taken = take;
            res.next_pc      = target;
         end
         default: begin
            res.status = rsx_pkg::ST_OPCODE;
         end
      endcase
   end

endmodule

>>> hw/rtl/rv32i_subset_executor.sv
// Small RV32I subset machine built around one word memory (MEM_BYTES/4 words, one read
// and one write port, registered read) and a 32-entry register file with two registered
// read ports. After reset the block sweeps both memories to zero, one word a cycle, and
// holds busy high until the sweep is done. A command is taken when start is high and
// busy is low. Loads, rejected commands and unknown codes answer in the next cycle from
// the registered result; register and memory reads answer through the READ state. A step
// runs fetch from the word memory, register file read, then execute and write back, and
// lw adds a load state for its data read from the same memory; faults found before the
// fetch answer like rejected commands. Every command yields exactly one result, shown for
// one cycle with rsp_valid high; the receiver cannot hold it, and a new command may be
// given in that same cycle.
`include "rv32i_subset_executor_defines.svh"

module rv32i_subset_executor #(
   parameter int MEM_BYTES      = rsx_pkg::MEM_BYTES_DEF,
   parameter int TEXT_WORDS_MAX = rsx_pkg::TEXT_WORDS_MAX_DEF,
   parameter int STEP_LIMIT     = rsx_pkg::STEP_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rsx_pkg::req_type req_data,
   output logic             rsp_valid,
   output rsx_pkg::rsp_type rsp_data
);

   localparam int MEM_WORDS = MEM_BYTES / 4;
   localparam int WADDR_W   = $clog2(MEM_WORDS);
   localparam int PC_W      = $clog2(MEM_BYTES + 1);
   localparam int TEXT_MAX  = (TEXT_WORDS_MAX < MEM_WORDS) ? TEXT_WORDS_MAX : MEM_WORDS;
   localparam int TC_W      = $clog2(TEXT_MAX + 1);
   localparam int SC_W      = $clog2(STEP_LIMIT + 1);
   localparam logic [31:0] MEM_LAST = 32'(MEM_BYTES - 4);

   rsx_pkg::fsm_type state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [TC_W-1:0]    text_count_ff, text_count_in;
   logic [SC_W-1:0]    step_count_ff, step_count_in;
   logic               data_seen_ff, data_seen_in;
   logic               started_ff, started_in;
   logic               stopped_ff, stopped_in;
   logic [WADDR_W-1:0] clr_idx_ff, clr_idx_in;
   rsx_pkg::req_type   req_ff, req_in;
   logic [31:0]        insn_ff, insn_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsx_pkg::rsp_type   rsp_ff, rsp_in;

   logic               accept;
   logic [31:0]        pc32;
   logic [31:0]        step32;
   logic [31:0]        text_end;
   logic               limit_hit;
   logic               halt_hit;
   logic               pc_bad;
   logic               text_full;
   logic               data_bad;
   logic               rd_in_range;
   logic               held_in_range;

   logic               mem_we;
   logic [WADDR_W-1:0] mem_waddr;
   logic [31:0]        mem_wdata;
   logic               mem_re;
   logic [WADDR_W-1:0] mem_raddr;
   logic [31:0]        mem_rdata;

   logic               rf_we;
   logic [4:0]         rf_waddr;
   logic [31:0]        rf_wdata;
   logic               rf_re_a;
   logic [4:0]         rf_raddr_a;
   logic               rf_re_b;
   logic [4:0]         rf_raddr_b;
   logic [31:0]        rf_rdata_a;
   logic [31:0]        rf_rdata_b;

   rsx_pkg::exec_res_type ex;

   rsx_word_mem #(
      .MEM_WORDS(MEM_WORDS)
   ) u_word_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   rsx_regfile u_regfile (
      .clock   (clock),
      .we      (rf_we),
      .waddr   (rf_waddr),
      .wdata   (rf_wdata),
      .re_a    (rf_re_a),
      .raddr_a (rf_raddr_a),
      .re_b    (rf_re_b),
      .raddr_b (rf_raddr_b),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   rsx_exec #(
      .MEM_BYTES(MEM_BYTES)
   ) u_exec (
      .insn     (insn_ff),
      .rs1_val  (rf_rdata_a),
      .rs2_val  (rf_rdata_b),
      .pc       (pc32),
      .text_end (text_end),
      .res      (ex)
   );

   assign busy   = (state_ff != rsx_pkg::FSM_IDLE);
   assign accept = start && !busy;

   assign pc32     = 32'(pc_ff);
   assign step32   = 32'(step_count_ff);
   assign text_end = 32'(text_count_ff) << 2;

   assign limit_hit = step32 >= 32'(STEP_LIMIT);
   assign halt_hit  = pc32 == text_end;
   assign pc_bad    = (pc32[1:0] != 2'd0) || (pc32 + 32'd4 > 32'(MEM_BYTES)) ||
                      ((pc32 >> 2) >= 32'(text_count_ff));
   assign text_full = 32'(text_count_ff) >= 32'(TEXT_MAX);
   assign data_bad  = (req_data.addr[1:0] != 2'd0) || (req_data.addr > MEM_LAST) ||
                      (req_data.addr < text_end);
   assign rd_in_range   = req_data.addr[31:2] < 30'(MEM_WORDS);
   assign held_in_range = req_ff.addr[31:2] < 30'(MEM_WORDS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rsx_pkg::FSM_CLEAR: begin
            if (clr_idx_ff == WADDR_W'(MEM_WORDS - 1)) begin
               state_in = rsx_pkg::FSM_IDLE;
            end
         end
         rsx_pkg::FSM_IDLE: begin
            if (accept) begin
               if (req_data.cmd == rsx_pkg::CMD_READ_REG ||
                   req_data.cmd == rsx_pkg::CMD_READ_MEM) begin
                  state_in = rsx_pkg::FSM_READ;
               end else if (req_data.cmd == rsx_pkg::CMD_STEP && !stopped_ff &&
                            !limit_hit && !halt_hit && !pc_bad) begin
                  state_in = rsx_pkg::FSM_FETCH;
               end
            end
         end
         rsx_pkg::FSM_READ:  state_in = rsx_pkg::FSM_IDLE;
         rsx_pkg::FSM_FETCH: state_in = rsx_pkg::FSM_EXEC;
         rsx_pkg::FSM_EXEC: begin
            if (ex.status == rsx_pkg::ST_OK && ex.is_load) begin
               state_in = rsx_pkg::FSM_LOAD;
            end else begin
               state_in = rsx_pkg::FSM_IDLE;
            end
         end
         rsx_pkg::FSM_LOAD:  state_in = rsx_pkg::FSM_IDLE;
         default:            state_in = rsx_pkg::FSM_IDLE;
      endcase
   end

   // datapath, memory ports and result
   always_comb begin
      pc_in         = pc_ff;
      text_count_in = text_count_ff;
      step_count_in = step_count_ff;
      data_seen_in  = data_seen_ff;
      started_in    = started_ff;
      stopped_in    = stopped_ff;
      clr_idx_in    = clr_idx_ff;
      req_in        = req_ff;
      insn_in       = insn_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      rf_we         = 1'b0;
      rf_waddr      = '0;
      rf_wdata      = '0;
      rf_re_a       = 1'b0;
      rf_raddr_a    = '0;
      rf_re_b       = 1'b0;
      rf_raddr_b    = '0;

      unique case (state_ff)
         rsx_pkg::FSM_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            rf_we      = (clr_idx_ff[WADDR_W-1:5] == '0);
            rf_waddr   = clr_idx_ff[4:0];
            clr_idx_in = clr_idx_ff + WADDR_W'(1);
         end
         rsx_pkg::FSM_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               rsp_valid_in = 1'b1;
               unique case (req_data.cmd)
                  rsx_pkg::CMD_READ_REG: begin
                     rsp_valid_in = 1'b0;
                     rf_re_a      = 1'b1;
                     rf_raddr_a   = req_data.addr[4:0];
                  end
                  rsx_pkg::CMD_READ_MEM: begin
                     rsp_valid_in = 1'b0;
                     mem_re       = rd_in_range;
                     mem_raddr    = req_data.addr[WADDR_W+1:2];
                  end
                  rsx_pkg::CMD_STEP: begin
                     if (stopped_ff) begin
                        rsp_in.status = rsx_pkg::ST_STOPPED;
                     end else begin
                        started_in        = 1'b1;
                        rsp_in.step_index = step32[9:0];
                        rsp_in.pc         = pc32[10:0];
                        if (limit_hit || halt_hit || pc_bad) begin
                           stopped_in = 1'b1;
                           if (limit_hit) begin
                              rsp_in.status = rsx_pkg::ST_LIMIT;
                           end else if (halt_hit) begin
                              rsp_in.status = rsx_pkg::ST_HALT;
                           end else begin
                              rsp_in.status = rsx_pkg::ST_PC_OUT;
                           end
                        end else begin
                           // fetch; the result comes after execute
                           rsp_valid_in = 1'b0;
                           mem_re       = 1'b1;
                           mem_raddr    = pc32[WADDR_W+1:2];
                        end
                     end
                  end
                  rsx_pkg::CMD_LOAD_TEXT: begin
                     if (stopped_ff) begin
                        rsp_in.status = rsx_pkg::ST_STOPPED;
                     end else if (started_ff) begin
                        rsp_in.status = rsx_pkg::ST_STARTED;
                     end else if (data_seen_ff) begin
                        rsp_in.status = rsx_pkg::ST_TEXT_LATE;
                     end else if (text_full) begin
                        rsp_in.status = rsx_pkg::ST_TEXT_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = WADDR_W'(text_count_ff);
                        mem_wdata     = req_data.word;
                        text_count_in = text_count_ff + TC_W'(1);
                     end
                  end
                  rsx_pkg::CMD_LOAD_DATA: begin
                     if (stopped_ff) begin
                        rsp_in.status = rsx_pkg::ST_STOPPED;
                     end else if (started_ff) begin
                        rsp_in.status = rsx_pkg::ST_STARTED;
                     end else if (data_bad) begin
                        rsp_in.status = rsx_pkg::ST_DATA_ADDR;
                     end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = req_data.addr[WADDR_W+1:2];
                        mem_wdata    = req_data.word;
                        data_seen_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end
         rsx_pkg::FSM_READ: begin
            rsp_valid_in = 1'b1;
            if (req_ff.cmd == rsx_pkg::CMD_READ_REG) begin
               rsp_in.read_data = rf_rdata_a;
            end else begin
               rsp_in.read_data = held_in_range ? mem_rdata : 32'd0;
            end
         end
         rsx_pkg::FSM_FETCH: begin
            insn_in    = mem_rdata;
            rf_re_a    = 1'b1;
            rf_raddr_a = mem_rdata[19:15];
            rf_re_b    = 1'b1;
            rf_raddr_b = mem_rdata[24:20];
         end
         rsx_pkg::FSM_EXEC: begin
            rsp_in.step_index = step32[9:0];
            rsp_in.pc         = pc32[10:0];
            rsp_in.insn       = insn_ff;
            if (ex.status != rsx_pkg::ST_OK) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ex.status;
               stopped_in    = 1'b1;
            end else if (ex.is_load) begin
               mem_re    = 1'b1;
               mem_raddr = ex.mem_addr[WADDR_W+1:2];
            end else begin
               rsp_valid_in        = 1'b1;
               rf_we               = ex.reg_we && (ex.dest_reg != 5'd0);
               rf_waddr            = ex.dest_reg;
               rf_wdata            = ex.wb_value;
               mem_we              = ex.mem_we;
               mem_waddr           = ex.mem_addr[WADDR_W+1:2];
               mem_wdata           = ex.write_value;
               rsp_in.dest_reg     = ex.dest_reg;
               rsp_in.write_value  = ex.write_value;
               rsp_in.mem_addr     = ex.mem_addr;
               rsp_in.branch_taken = ex.branch_taken;
               rsp_in.next_pc      = ex.next_pc[10:0];
               pc_in               = ex.next_pc[PC_W-1:0];
               step_count_in       = step_count_ff + SC_W'(1);
            end
         end
         rsx_pkg::FSM_LOAD: begin
            rsp_valid_in       = 1'b1;
            rf_we              = (ex.dest_reg != 5'd0);
            rf_waddr           = ex.dest_reg;
            rf_wdata           = mem_rdata;
            rsp_in.step_index  = step32[9:0];
            rsp_in.pc          = pc32[10:0];
            rsp_in.insn        = insn_ff;
            rsp_in.dest_reg    = ex.dest_reg;
            rsp_in.write_value = (ex.dest_reg != 5'd0) ? mem_rdata : 32'd0;
            rsp_in.mem_addr    = ex.mem_addr;
            rsp_in.next_pc     = ex.next_pc[10:0];
            pc_in              = ex.next_pc[PC_W-1:0];
            step_count_in      = step_count_ff + SC_W'(1);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rsx_pkg::FSM_CLEAR;
         pc_ff         <= '0;
         text_count_ff <= '0;
         step_count_ff <= '0;
         data_seen_ff  <= 1'b0;
         started_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
         clr_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         text_count_ff <= text_count_in;
         step_count_ff <= step_count_in;
         data_seen_ff  <= data_seen_in;
         started_ff    <= started_in;
         stopped_ff    <= stopped_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      insn_ff <= insn_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RSX_ASSERT_IMPLY(a_mem_one_access, clock, reset, mem_we, !mem_re, "word memory read and write in one cycle")
   `RSX_ASSERT_IMPLY(a_no_x0_write, clock, reset, rf_we && state_ff != rsx_pkg::FSM_CLEAR, rf_waddr != 5'd0, "write to x0")
   `RSX_ASSERT_NEXT(a_stop_sticks, clock, reset, stopped_ff, stopped_ff, "stopped flag dropped")
   `RSX_ASSERT_IMPLY(a_step_bound, clock, reset, 1'b1, step32 <= 32'(STEP_LIMIT), "step count past limit")
   `RSX_ASSERT_IMPLY(a_no_rsp_in_clear, clock, reset, rsp_valid_ff, $past(state_ff) != rsx_pkg::FSM_CLEAR, "result during clearing pass")

endmodule
